// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the FIFO block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and ignored in reset.
`define BF_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock and ignored in reset.
`define BF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/bfifo_pkg.sv =====
// Shared constants, codes and control types of the bounded FIFO block.
`default_nettype none

package bfifo_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CAP_W     = 5;
   localparam int CNT_OUT_W = 5;
   localparam int ARITH_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int CMD_W     = 3;
   localparam int STAT_W    = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic [CMD_W-1:0] CMD_PUT      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_GET      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SHUTDOWN = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] ST_DOWN  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request word and start the slot read
      logic execute;   // apply the command and load the response register
   } dp_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bfifo_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bfifo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bfifo_ctrl.sv =====
// Controller state machine that sequences one FIFO command at a time.
`default_nettype none

module bfifo_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output bfifo_pkg::dp_ctl_type      ctl
);

   import bfifo_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_free;

   // The response register can take a new word when empty or being drained.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      ctl.capture = 1'b0;
      ctl.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               ctl.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ctl.execute || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bfifo_dp.sv =====
// Datapath: capacity register, pointers, count, slot memory and response word.
`default_nettype none

module bfifo_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bfifo_pkg::dp_ctl_type               ctl,
   input  wire logic [bfifo_pkg::CMD_W-1:0]         req_command,
   input  wire logic [bfifo_pkg::DATA_WIDTH-1:0]    req_write_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bfifo_pkg::CAP_W-1:0]         csr_capacity,
   output logic      [bfifo_pkg::DATA_WIDTH-1:0]    rsp_read_data,
   output logic      [bfifo_pkg::STAT_W-1:0]        rsp_status,
   output logic      [bfifo_pkg::CNT_OUT_W-1:0]     rsp_fill_count,
   output logic      [bfifo_pkg::CNT_OUT_W-1:0]     rsp_room_left,
   output logic                                     rsp_full_flag,
   output logic                                     rsp_empty_flag,
   output logic                                     rsp_running_flag
);

   import bfifo_pkg::*;

   localparam logic [ARITH_W-1:0] DEPTH_A  = ARITH_W'(DEPTH);
   localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);

   logic [CMD_W-1:0]      cmd_ff;
   logic [DATA_WIDTH-1:0] wdata_ff;
   logic [CAP_W-1:0]      capacity_ff;
   logic [PTR_W-1:0]      head_ff;
   logic [PTR_W-1:0]      head_in;
   logic [PTR_W-1:0]      tail_ff;
   logic [PTR_W-1:0]      tail_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  running_ff;
   logic                  running_in;

   logic [DATA_WIDTH-1:0] rd_word_ff;
   logic [DATA_WIDTH-1:0] rd_word_in;
   logic [STAT_W-1:0]     status_ff;
   logic [STAT_W-1:0]     status_in;
   logic [CNT_OUT_W-1:0]  fill_ff;
   logic [CNT_OUT_W-1:0]  fill_in;
   logic [CNT_OUT_W-1:0]  room_ff;
   logic [CNT_OUT_W-1:0]  room_in;
   logic                  full_ff;
   logic                  full_in;
   logic                  empty_ff;
   logic                  empty_in;
   logic                  run_flag_ff;

   logic [ARITH_W-1:0]    cap_ext;
   logic [ARITH_W-1:0]    cap_eff;
   logic [ARITH_W-1:0]    count_ext;
   logic [ARITH_W-1:0]    count_new_ext;
   logic                  wr_en;
   logic [DATA_WIDTH-1:0] slot_data;

   assign csr_ready = 1'b1;

   // Capacity above the storage depth saturates to the depth.
   assign cap_ext   = ARITH_W'(capacity_ff);
   assign cap_eff   = (cap_ext > DEPTH_A) ? DEPTH_A : cap_ext;
   assign count_ext = ARITH_W'(count_ff);

   bfifo_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wdata_ff),
      .rd_en   (ctl.capture),
      .rd_addr (head_ff),
      .rd_data (slot_data)
   );

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      running_in = running_ff;
      wr_en      = 1'b0;
      rd_word_in = '0;
      status_in  = ST_OK;
      unique case (cmd_ff) inside
         CMD_PUT: begin
            if (!running_ff) begin
               status_in = ST_DOWN;
            end else if (count_ext >= cap_eff) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = ctl.execute;
               tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_GET, CMD_PEEK: begin
            if (!running_ff) begin
               status_in = ST_DOWN;
            end else if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               rd_word_in = slot_data;
               if (cmd_ff == CMD_GET) begin
                  head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         CMD_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         CMD_SHUTDOWN: begin
            if (running_ff) begin
               running_in = 1'b0;
               head_in    = '0;
               tail_in    = '0;
               count_in   = '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign count_new_ext = ARITH_W'(count_in);
   assign fill_in  = CNT_OUT_W'(count_new_ext);
   assign room_in  = (count_new_ext > cap_eff) ? '0 : CNT_OUT_W'(cap_eff - count_new_ext);
   assign full_in  = (count_new_ext >= cap_eff);
   assign empty_in = (count_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         running_ff  <= 1'b1;
      end else begin
         if (csr_valid) begin
            capacity_ff <= csr_capacity;
         end
         if (ctl.execute) begin
            head_ff    <= head_in;
            tail_ff    <= tail_in;
            count_ff   <= count_in;
            running_ff <= running_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= req_command;
         wdata_ff <= req_write_data;
      end
      if (ctl.execute) begin
         rd_word_ff  <= rd_word_in;
         status_ff   <= status_in;
         fill_ff     <= fill_in;
         room_ff     <= room_in;
         full_ff     <= full_in;
         empty_ff    <= empty_in;
         run_flag_ff <= running_in;
      end
   end

   assign rsp_read_data    = rd_word_ff;
   assign rsp_status       = status_ff;
   assign rsp_fill_count   = fill_ff;
   assign rsp_room_left    = room_ff;
   assign rsp_full_flag    = full_ff;
   assign rsp_empty_flag   = empty_ff;
   assign rsp_running_flag = run_flag_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_fifo_with_peek_clear_shutdown.sv =====
// Top level of the bounded FIFO with put, get, peek, clear and shutdown commands.
`default_nettype none

// This block is a circular FIFO of 32-bit words whose capacity is set at run
// time through the csr port (1 to 16 words, values above the storage depth act
// as the depth, zero makes every put report full). Each request word carries one
// command and produces exactly one response word with the read data, a status,
// the fill count, the room left and the full, empty and running flags. A command
// that cannot proceed never waits: it reports full, empty or not operational and
// leaves the queue untouched. Clear works at any time, also after shutdown, and
// shutdown empties the queue and holds it down until reset. A command has a
// capture step, where the request is accepted and the head slot is read from
// the slot RAM, whose read port is registered, and an execute step, where the
// command is applied and the response register is loaded; no new command is
// accepted until the execute step of the last one is done. A new request is
// accepted while the previous response still waits in its register; the block
// only holds in its execute step when that register is occupied and stalled.
// The slot RAM is never cleared, so no clearing pass follows reset; capacity
// may be written whenever the block is idle, and the csr port is always ready.
module bounded_fifo_with_peek_clear_shutdown (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [bfifo_pkg::CMD_W-1:0]         req_command,
   input  wire logic [bfifo_pkg::DATA_WIDTH-1:0]    req_write_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [bfifo_pkg::DATA_WIDTH-1:0]    rsp_read_data,
   output logic      [bfifo_pkg::STAT_W-1:0]        rsp_status,
   output logic      [bfifo_pkg::CNT_OUT_W-1:0]     rsp_fill_count,
   output logic      [bfifo_pkg::CNT_OUT_W-1:0]     rsp_room_left,
   output logic                                     rsp_full_flag,
   output logic                                     rsp_empty_flag,
   output logic                                     rsp_running_flag,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bfifo_pkg::CAP_W-1:0]         csr_capacity
);

   import bfifo_pkg::*;

   // Command strobes from the controller to the datapath.
   dp_ctl_type ctl;

   // The controller owns the request and response handshakes and the response valid bit.
   bfifo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   // The datapath holds the queue state, the slot RAM and the response word.
   bfifo_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_command      (req_command),
      .req_write_data   (req_write_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_capacity     (csr_capacity),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .rsp_fill_count   (rsp_fill_count),
      .rsp_room_left    (rsp_room_left),
      .rsp_full_flag    (rsp_full_flag),
      .rsp_empty_flag   (rsp_empty_flag),
      .rsp_running_flag (rsp_running_flag)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bfifo_chk.sv =====
// Port-level checker for the bounded FIFO, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module bfifo_chk (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [bfifo_pkg::DATA_WIDTH-1:0]    rsp_read_data,
   input  wire logic [bfifo_pkg::STAT_W-1:0]        rsp_status,
   input  wire logic [bfifo_pkg::CNT_OUT_W-1:0]     rsp_room_left,
   input  wire logic                                rsp_full_flag,
   input  wire logic                                rsp_empty_flag,
   input  wire logic                                rsp_running_flag
);

   import bfifo_pkg::*;

   // A stalled response stays valid with the same word.
   `BF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data) && $stable(rsp_status))

   // One command at a time: the cycle after an accept the request side is stalled.
   `BF_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

   // A full queue has no room left.
   `BF_ASSERT(a_full_no_room, rsp_valid && rsp_full_flag, rsp_room_left == '0)

   // An empty report carries zero data and the empty flag.
   `BF_ASSERT(a_empty_report, rsp_valid && (rsp_status == ST_EMPTY), (rsp_read_data == '0) && rsp_empty_flag)

   // A full report on a running queue shows the full flag.
   `BF_ASSERT(a_full_report, rsp_valid && (rsp_status == ST_FULL), rsp_full_flag && rsp_running_flag)

endmodule

bind bounded_fifo_with_peek_clear_shutdown bfifo_chk u_bfifo_chk (.*);

`default_nettype wire
